[rtl/core/tgc_pkg.sv]
// Package: shared types, constants and codes of the touch gesture classifier.
package tgc_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned TAP_W   = 2;

	localparam logic [TAP_W-1:0] TRIPLE_TAPS = TAP_W'(3);

	localparam logic [CFG_W-1:0] DEBOUNCE_RST  = CFG_W'(50);
	localparam logic [CFG_W-1:0] LONG_RST      = CFG_W'(800);
	localparam logic [CFG_W-1:0] WINDOW_RST    = CFG_W'(400);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_LONG     = 2'd1,
		CFG_WINDOW   = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		GEST_NONE   = 3'd0,
		GEST_SHORT  = 3'd1,
		GEST_DOUBLE = 3'd2,
		GEST_LONG   = 3'd3,
		GEST_TRIPLE = 3'd4
	} gesture_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] long_press_time;
		logic [CFG_W-1:0] multi_tap_window;
	} tgc_cfg_t;

	typedef struct packed {
		logic              last_raw;
		logic              pressed;
		logic [TIME_W-1:0] edge_time;
		logic [TIME_W-1:0] press_time;
		logic [TIME_W-1:0] release_time;
		logic              long_done;
		logic [TAP_W-1:0]  tap_count;
	} tgc_state_t;

endpackage

[rtl/core/tgc_ifs.sv]
// Interfaces: sample channel and gesture result channel.
interface tgc_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic        raw_level;

	modport source (output valid, output now_ms, output raw_level, input ready);
	modport sink   (input valid, input now_ms, input raw_level, output ready);
endinterface

interface tgc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] gesture;

	modport source (output valid, output gesture, input ready);
	modport sink   (input valid, input gesture, output ready);
endinterface

[rtl/core/touch_gesture_classifier_core.sv]
// Top level: debounced touch input with tap, double, triple and long press detection.
// A result item passes through the input register, then the result register, and a stall
// on the result side can hold it in either.
// Throughput: one sample per cycle unless the result side stalls, limited by the single compute stage.
// A stalled result holds in the output register; the input stage keeps taking samples
// until it is full as well.
// Reset (arst_n low, async): config to 50/800/400 ms, all tracking state to zero.
module touch_gesture_classifier_core import tgc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	tgc_sample_if.sink           samples,
	tgc_result_if.source         results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// config registers
	tgc_cfg_t cfg_q;

	// tracking state, updated once per sample leaving the input stage
	tgc_state_t st_q;
	tgc_state_t st_nxt;

	// input stage
	logic              valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic              raw_s1;

	// result register
	logic     res_valid_q;
	gesture_t res_gest_q;
	gesture_t gest_nxt;

	logic advance;

	// stage moves whenever the result register is empty or being drained
	assign advance       = !res_valid_q || results.ready;
	assign samples.ready = !valid_s1 || advance;

	assign results.valid   = res_valid_q;
	assign results.gesture = res_gest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time    <= DEBOUNCE_RST;
			cfg_q.long_press_time  <= LONG_RST;
			cfg_q.multi_tap_window <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEBOUNCE: cfg_q.debounce_time    <= cfg_data;
				CFG_LONG:     cfg_q.long_press_time  <= cfg_data;
				CFG_WINDOW:   cfg_q.multi_tap_window <= cfg_data;
				default:      ; // unmapped index: ignored
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			now_s1 <= samples.now_ms;
			raw_s1 <= samples.raw_level;
		end
	end

	tgc_step u_step (
		.cur       (st_q),
		.cfg       (cfg_q),
		.now_ms    (now_s1),
		.raw_level (raw_s1),
		.nxt       (st_nxt),
		.gesture   (gest_nxt)
	);

	// state commits exactly when the sample moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (valid_s1 && advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_gest_q <= gest_nxt;
		end
	end

endmodule

[rtl/core/tgc_step.sv]
// Next-state and gesture logic for one sample.
module tgc_step import tgc_pkg::*; (
	input  tgc_state_t        cur,
	input  tgc_cfg_t          cfg,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              raw_level,
	output tgc_state_t        nxt,
	output gesture_t          gesture
);

	logic              raw_edge;
	logic [TIME_W-1:0] edge_dt;
	logic [TIME_W-1:0] press_dt;
	logic [TIME_W-1:0] rel_dt;
	logic              deb_ok;
	logic              take;
	logic              press_now;
	logic              rel_count;
	logic              long_ok;
	logic              win_ok;
	tgc_state_t        mid;

	assign raw_edge = raw_level != cur.last_raw;
	assign edge_dt  = now_ms - cur.edge_time;
	assign press_dt = now_ms - cur.press_time;
	assign rel_dt   = now_ms - cur.release_time;

	// a fresh edge restarts the timer: elapsed time is zero
	assign deb_ok = raw_edge ? (cfg.debounce_time == '0)
	                         : (edge_dt >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time});
	assign take      = deb_ok && (raw_level != cur.pressed);
	assign press_now = take && raw_level;
	assign rel_count = take && !raw_level && !cur.long_done;

	assign long_ok = press_now ? (cfg.long_press_time == '0)
	                           : (press_dt >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_time});
	assign win_ok  = rel_count ? (cfg.multi_tap_window == '0)
	                           : (rel_dt >= {{(TIME_W-CFG_W){1'b0}}, cfg.multi_tap_window});

	always_comb begin
		mid = cur;
		if (raw_edge) begin
			mid.last_raw  = raw_level;
			mid.edge_time = now_ms;
		end
		if (take) begin
			mid.pressed = raw_level;
		end
		if (press_now) begin
			mid.press_time = now_ms;
			mid.long_done  = 1'b0;
		end
		if (rel_count) begin
			mid.tap_count    = cur.tap_count + TAP_W'(1);
			mid.release_time = now_ms;
		end

		nxt     = mid;
		gesture = GEST_NONE;
		if (mid.pressed && !mid.long_done && long_ok) begin
			nxt.long_done = 1'b1;
			nxt.tap_count = '0;
			gesture       = GEST_LONG;
		end else if (mid.tap_count >= TRIPLE_TAPS) begin
			nxt.tap_count = '0;
			gesture       = GEST_TRIPLE;
		end else if (mid.tap_count != '0 && !mid.pressed && win_ok) begin
			nxt.tap_count = '0;
			gesture       = (mid.tap_count == TAP_W'(1)) ? GEST_SHORT : GEST_DOUBLE;
		end
	end

endmodule

[rtl/core/tgc_checker.sv]
// Checker: port-level properties of the classifier, bound to the top level.
module tgc_checker import tgc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] gesture
);

	logic out_acc;
	assign out_acc = out_valid && out_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_gest_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(gesture))
		else $error("gesture changed while stalled");

	a_gest_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gesture <= GEST_TRIPLE)
		else $error("gesture code out of range");

	// a long press needs a release and a new press before it can fire again
	a_long_twice: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && gesture == GEST_LONG |=> !(out_acc && gesture == GEST_LONG))
		else $error("long press reported on consecutive items");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind touch_gesture_classifier_core tgc_checker u_tgc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.gesture   (results.gesture)
);

[tb/sv/tb.sv]
// Testbench for the touch gesture classifier core: stimulus, prediction and checks.
module tb;
	import tgc_pkg::*;

	// Longest run of cycles with no item moving on either side before giving up.
	localparam int STALL_LIMIT = 2000;
	// Cycles to let the two-stage pipe empty before a register write or the end.
	localparam int SETTLE_CYCLES = 4;
	// Receiver hold-off length, long enough to back up the whole pipe.
	localparam int HOLD_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	// Keeps its own copy of the classifier state and registers, works out the gesture
	// for every accepted sample and checks each result item against the oldest one.
	class gesture_scoreboard;
		logic [CFG_W-1:0]  debounce_ms, long_ms, window_ms;
		logic              seen_level, held, long_fired;
		logic [TIME_W-1:0] t_edge, t_press, t_release;
		logic [TAP_W-1:0]  taps;
		gesture_t          pending[$];
		int                mismatches;

		function new();
			debounce_ms = DEBOUNCE_RST;
			long_ms     = LONG_RST;
			window_ms   = WINDOW_RST;
			seen_level  = 1'b0;
			held        = 1'b0;
			long_fired  = 1'b0;
			t_edge      = '0;
			t_press     = '0;
			t_release   = '0;
			taps        = '0;
			mismatches  = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
			case (idx)
				CFG_DEBOUNCE: debounce_ms = value;
				CFG_LONG:     long_ms     = value;
				CFG_WINDOW:   window_ms   = value;
				default: ;
			endcase
		endfunction

		function void note_sample(logic [TIME_W-1:0] t, logic level);
			logic [TIME_W-1:0] since_edge, since_press, since_release;
			gesture_t g;
			g = GEST_NONE;
			// any change of the raw level restarts the debounce timer
			if (level != seen_level) begin
				seen_level = level;
				t_edge = t;
			end
			since_edge = t - t_edge;
			if (since_edge >= TIME_W'(debounce_ms) && level != held) begin
				held = level;
				if (held) begin
					t_press = t;
					long_fired = 1'b0;
				end else if (!long_fired) begin
					// release after a long press counts no tap
					taps = taps + 1'b1;
					t_release = t;
				end
			end
			since_press   = t - t_press;
			since_release = t - t_release;
			// long press wins over a triple, which wins over short/double
			if (held && !long_fired && since_press >= TIME_W'(long_ms)) begin
				long_fired = 1'b1;
				taps = '0;
				g = GEST_LONG;
			end else if (taps >= TRIPLE_TAPS) begin
				taps = '0;
				g = GEST_TRIPLE;
			end else if (taps != '0 && !held && since_release >= TIME_W'(window_ms)) begin
				g = (taps == TAP_W'(1)) ? GEST_SHORT : GEST_DOUBLE;
				taps = '0;
			end
			pending.push_back(g);
		endfunction

		function void check_result(logic [2:0] got);
			gesture_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected gesture item %0d with nothing outstanding", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("gesture mismatch: expected %0d, got %0d", want, got);
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		// items still owed at the end are failures too
		function int failures();
			return mismatches + pending.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	tgc_sample_if sample_ch();
	tgc_result_if result_ch();

	touch_gesture_classifier_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (sample_ch),
		.results  (result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	gesture_scoreboard sb = new();

	int items_in = 0;       // samples accepted by the block
	int items_sent = 0;     // samples the stimulus has pushed through
	int stall_cycles = 0;   // cycles in a row with no item accepted anywhere
	logic [TIME_W-1:0] clock_ms;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both sides stop idling for a stretch in the middle of the run.
	function automatic bit quiet_stretch();
		return items_in >= 170 && items_in < 260;
	endfunction

	// Monitor: sample on the rising edge, feed the predictor, check results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				sb.note_sample(sample_ch.now_ms, sample_ch.raw_level);
				items_in++;
			end
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.gesture);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Watchdog: nothing moving for too long means the block hung.
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	// Result side: random stalls, plus two long hold-offs that back the pipe up
	// into the sample side while the sender keeps offering items.
	initial begin
		int hold_left;
		bit first_hold, second_hold;
		hold_left = 0;
		first_hold = 1'b0;
		second_hold = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (!first_hold && items_in >= 80) begin
				first_hold = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (!second_hold && items_in >= 330) begin
				second_hold = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= quiet_stretch() || $urandom_range(99) >= 12;
			end
		end
	end

	// Offer one sample from a falling edge, return on the falling edge after it
	// was taken. Random gaps lower valid first.
	task automatic send_sample(input logic [TIME_W-1:0] t, input logic level);
		while (!quiet_stretch() && $urandom_range(99) < 12) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.now_ms    <= t;
		sample_ch.raw_level <= level;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every owed gesture is back and the pipe is empty.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes all three registers back to back; only done while the block is idle.
	task automatic program_regs(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
			input logic [CFG_W-1:0] win);
		cfg_idx_t idx;
		logic [CFG_W-1:0] vals[3];
		vals[0] = deb;
		vals[1] = lng;
		vals[2] = win;
		drain();
		for (int i = 0; i < 3; i++) begin
			idx = cfg_idx_t'(i);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[i];
			sb.write_reg(idx, vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Hold one level for span ms: first sample right at the edge, then random strides.
	task automatic hold_level(input logic level, input int unsigned span);
		int unsigned elapsed, stride;
		elapsed = 0;
		while (elapsed < span) begin
			stride = (elapsed == 0) ? 1 : $urandom_range(span / 3 + 1, 1);
			elapsed += stride;
			clock_ms += stride;
			send_sample(clock_ms, level);
		end
	endtask

	// Contact bounce: a few 1 ms glitches, shorter than the debounce time.
	task automatic bounce(input int unsigned deb);
		if (deb >= 4 && $urandom_range(3) == 0) begin
			repeat ($urandom_range(3, 1)) begin
				clock_ms += 1;
				send_sample(clock_ms, 1'($urandom));
			end
		end
	endtask

	// One gesture shaped around the current register values: mostly tap runs
	// and long presses, some pure noise with jumps in time.
	task automatic play_gesture(input int unsigned deb, input int unsigned lng,
			input int unsigned win);
		int unsigned roll, n_taps, gap;
		roll = $urandom_range(99);
		if (roll < 10) begin
			repeat ($urandom_range(4, 1))
				send_sample($urandom, 1'($urandom));
		end else if (roll < 35) begin
			bounce(deb);
			hold_level(1'b1, deb + lng + $urandom_range(lng / 2 + 1, 1));
			bounce(deb);
			hold_level(1'b0, deb + win + $urandom_range(win / 2 + 1, 1));
		end else begin
			n_taps = $urandom_range(4, 1);
			for (int i = 0; i < n_taps; i++) begin
				bounce(deb);
				hold_level(1'b1, deb + $urandom_range(lng / 2 + 1, 1));
				bounce(deb);
				gap = $urandom_range(win / 2 + 1, 1);
				if (i == n_taps - 1)
					gap += win;
				hold_level(1'b0, deb + gap);
			end
		end
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
			input logic [CFG_W-1:0] win, input int quota);
		int start;
		program_regs(deb, lng, win);
		start = items_sent;
		while (items_sent - start < quota)
			play_gesture(deb, lng, win);
	endtask

	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= CFG_DEBOUNCE;
		cfg_data            <= '0;
		sample_ch.valid     <= 1'b0;
		sample_ch.now_ms    <= '0;
		sample_ch.raw_level <= 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed, reset register values (50/800/400) ---
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'hFFFF_FFF0, 1'b1);   // edge near the top of the time range
		send_sample(32'h0000_0030, 1'b1);   // press accepted across the wrap
		send_sample(32'h0000_0050, 1'b0);
		send_sample(32'h0000_0090, 1'b0);   // one tap counted
		send_sample(32'h0000_0020, 1'b1);   // time runs backwards: window looks expired
		send_sample(32'h0000_0060, 1'b1);   // press
		send_sample(32'h0000_0400, 1'b1);   // held past the long time
		send_sample(32'h0000_0410, 1'b0);
		send_sample(32'h0000_0450, 1'b0);   // release after long press: no tap
		send_sample(32'h0000_0800, 1'b0);

		// zero debounce, widest long and window: three taps make a triple at once
		program_regs('0, '1, '1);
		send_sample(32'd1000, 1'b1);
		send_sample(32'd1001, 1'b0);
		send_sample(32'd1002, 1'b1);
		send_sample(32'd1003, 1'b0);
		send_sample(32'd1004, 1'b1);
		send_sample(32'd1005, 1'b0);

		// zero long press time fires on the press itself
		program_regs('0, '0, '0);
		send_sample(32'd2000, 1'b1);
		send_sample(32'd2001, 1'b0);

		// zero window resolves the tap on its release
		program_regs('0, '1, '0);
		send_sample(32'd2002, 1'b1);
		send_sample(32'd2003, 1'b0);

		// --- random gesture streams under several register settings ---
		clock_ms = $urandom;
		run_phase(16'd5, 16'd40, 16'd25, 70);
		run_phase(16'd0, 16'd20, 16'd10, 70);
		run_phase(16'd3, 16'd0, 16'd0, 70);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 70);
		run_phase(16'd1, 16'hFFFF, 16'd1, 70);
		run_phase(CFG_W'($urandom_range(20)), CFG_W'($urandom_range(100)),
			CFG_W'($urandom_range(60)), 70);

		drain();
		repeat (8) @(negedge clk);
		if (sb.failures() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
